// ===== design/orb_pkg.sv =====
`default_nettype none

package orb_pkg;

    // payload widths
    localparam int WORD_W    = 32;
    localparam int LEN_REG_W = 5;

    // default store size and length register reset value
    localparam int                   DEPTH_DEFAULT = 16;
    localparam logic [LEN_REG_W-1:0] LEN_RESET     = LEN_REG_W'(16);

    // the word that marks an empty slot
    localparam logic [WORD_W-1:0] WORD_ONES = '1;

    // item kinds
    typedef enum logic {
        MODE_ADD    = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

endpackage

`default_nettype wire

// ===== design/orb_ram.sv =====
`default_nettype none

module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read a cycle, read returns the old contents
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/overwriting_ring_buffer_core.sv =====
`default_nettype none

// channel   direction  handshake           payload
// cfg       in         cfg_write           cfg_data (length in use)
// in        in         in_valid/in_stall   mode, word_in
// out       out        out_valid/out_stall word_out, underflow, now_empty
//
// one item per cycle while out_stall is low; a result goes from the input
// transfer through the middle stage (the ram's registered slot read) to the
// output register. after reset a clearing pass writes word_in to every slot,
// during which in_stall is high; configuration writes are taken throughout.
// a stalled output holds its result in the output register while one more
// item may wait in the middle stage; further items are then stalled.

module overwriting_ring_buffer_core
    #(
        parameter int DEPTH = orb_pkg::DEPTH_DEFAULT
    )
    (
        input  wire logic                          clk,
        input  wire logic                          rst_n,
        // configuration
        input  wire logic                          cfg_write,
        input  wire logic [orb_pkg::LEN_REG_W-1:0] cfg_data,
        // input channel
        input  wire logic                          in_valid,
        output logic                               in_stall,
        input  wire logic                          mode,
        input  wire logic [orb_pkg::WORD_W-1:0]    word_in,
        // output channel
        output logic                               out_valid,
        input  wire logic                          out_stall,
        output logic      [orb_pkg::WORD_W-1:0]    word_out,
        output logic                               underflow,
        output logic                               now_empty
    );

    import orb_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CW     = (FILL_W > LEN_REG_W) ? FILL_W : LEN_REG_W;
    localparam logic [CW-1:0]    DEPTH_C  = CW'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // control and pointer state
    logic [LEN_REG_W-1:0] length_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 clearing_reg;
    logic [IDX_W-1:0]     clr_idx_reg;

    // middle stage
    logic              p1_valid_reg, p1_valid_next;
    logic              p1_from_ram_reg, p1_from_ram_next;
    logic [WORD_W-1:0] p1_word_reg, p1_word_next;
    logic              p1_under_reg, p1_under_next;
    logic              p1_empty_reg, p1_empty_next;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_under_reg, out_under_next;
    logic              out_empty_reg, out_empty_next;

    // ram ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    logic              in_xfer;
    logic              out_xfer;
    logic              p1_move;
    logic [CW-1:0]     len_eff;
    logic [IDX_W-1:0]  acc_waddr;
    logic              acc_we;
    logic              is_full;
    logic              is_empty;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                              input logic [CW-1:0]    len);
        if (CW'(i) >= len - CW'(1))
            return '0;
        else
            return i + IDX_W'(1);
    endfunction

    orb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // handshakes
    assign out_xfer = out_valid_reg && !out_stall;
    assign p1_move  = p1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing_reg || (p1_valid_reg && !p1_move);
    assign in_xfer  = in_valid && !in_stall;

    // effective length, clamped to one..DEPTH
    always_comb
    begin
        if (length_reg == '0)
            len_eff = CW'(1);
        else if (CW'(length_reg) > DEPTH_C)
            len_eff = DEPTH_C;
        else
            len_eff = CW'(length_reg);
    end

    assign is_empty = (fill_reg == '0);
    assign is_full  = (CW'(fill_reg) >= len_eff);

    // pointer update and slot access for the item in transfer
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        acc_we           = 1'b0;
        acc_waddr        = tail_reg;
        ram_wdata        = word_in;
        ram_re           = 1'b0;
        p1_from_ram_next = 1'b0;
        p1_word_next     = word_in;
        p1_under_next    = 1'b0;
        if (in_xfer)
        begin
            if (mode_t'(mode) == MODE_ADD)
            begin
                acc_we = 1'b1;
                if (is_empty)
                begin
                    acc_waddr = tail_reg;
                    fill_next = FILL_W'(1);
                end
                else if (is_full)
                begin
                    tail_next = head_reg;
                    acc_waddr = head_reg;
                    head_next = adv(head_reg, len_eff);
                end
                else
                begin
                    tail_next = adv(tail_reg, len_eff);
                    acc_waddr = tail_next;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            else if (is_empty)
            begin
                p1_word_next  = WORD_ONES;
                p1_under_next = 1'b1;
            end
            else
            begin
                // read the oldest entry and mark its slot empty
                ram_re           = 1'b1;
                p1_from_ram_next = 1'b1;
                acc_we           = 1'b1;
                acc_waddr        = head_reg;
                ram_wdata        = WORD_ONES;
                if (fill_reg != FILL_W'(1))
                    head_next = adv(head_reg, len_eff);
                fill_next = fill_reg - FILL_W'(1);
            end
        end
    end

    // write port shared with the clearing pass
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
        end
        else
        begin
            ram_we    = acc_we;
            ram_waddr = acc_waddr;
        end
    end

    assign p1_empty_next = (fill_next == '0);

    // middle stage next values
    always_comb
    begin
        if (in_xfer)
            p1_valid_next = 1'b1;
        else if (p1_move)
            p1_valid_next = 1'b0;
        else
            p1_valid_next = p1_valid_reg;
    end

    // output stage next values
    always_comb
    begin
        out_word_next  = out_word_reg;
        out_under_next = out_under_reg;
        out_empty_next = out_empty_reg;
        if (p1_move)
        begin
            out_valid_next = 1'b1;
            out_word_next  = p1_from_ram_reg ? ram_rdata : p1_word_reg;
            out_under_next = p1_under_reg;
            out_empty_next = p1_empty_reg;
        end
        else if (out_xfer)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LEN_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                length_reg <= cfg_data;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                    clearing_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            p1_from_ram_reg <= p1_from_ram_next;
            p1_word_reg     <= p1_word_next;
            p1_under_reg    <= p1_under_next;
            p1_empty_reg    <= p1_empty_next;
        end
        out_word_reg  <= out_word_next;
        out_under_reg <= out_under_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign word_out  = out_word_reg;
    assign underflow = out_under_reg;
    assign now_empty = out_empty_reg;

`ifndef SYNTH
    // fill count stays within the store
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill_reg) <= DEPTH_C)
        else $error("fill count beyond store depth");

    // nothing is taken in while the store is being cleared
    a_no_xfer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !in_xfer)
        else $error("input transfer during clearing pass");

    // an empty remove reports all ones and an empty buffer
    a_underflow_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_under_reg) |-> (out_empty_reg && out_word_reg == WORD_ONES))
        else $error("underflow result malformed");

    // a remove that finds data leaves one fewer entry
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode_t'(mode) == MODE_REMOVE && !is_empty)
            |=> (fill_reg == $past(fill_reg) - FILL_W'(1)))
        else $error("remove did not decrement fill count");

    // a stalled result holds until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
